### rtl/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// types, constants and codes shared by the counted multiset table and its cells
// ----------------------------------------------------------------------------
package cmt_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int POS_W     = 4;
  localparam int SEL_W     = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int VAL_W     = 16;
  localparam int TOTAL_W   = 36;
  localparam int DIST_W    = 5;

  localparam logic [VAL_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_COUNT  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [VAL_W-1:0]   count;
    logic [VAL_W-1:0]   entry_value;
    logic [TOTAL_W-1:0] total;
    logic [DIST_W-1:0]  distinct;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               load;
    logic               inc;
    logic               dec;
    logic               del;
    logic               app;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   position;
    logic [CNT_W-1:0]   used;
  } ctl_t;

  // data rippling along the row of cells
  typedef struct packed {
    logic               hit_any;
    logic [VAL_W-1:0]   hit_count;
    logic               sel_any;
    logic [VAL_W-1:0]   sel_count;
    logic [VAL_W-1:0]   sel_value;
  } link_t;

endpackage

### rtl/cmt_cell.sv
// ----------------------------------------------------------------------------
// cmt_cell
// one table entry: value, count, match and position flags, chain reduction
// ----------------------------------------------------------------------------
module cmt_cell import cmt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  ctl_t             ctl,
  input  logic [VAL_W-1:0] nbr_value,
  input  logic [VAL_W-1:0] nbr_count,
  input  link_t            chain_in,
  output link_t            chain_out,
  output logic [VAL_W-1:0] value,
  output logic [VAL_W-1:0] count,
  output logic             hit
);

  logic sel;
  logic occupied;
  logic shift;

  assign occupied = CNT_W'(idx) < ctl.used;
  // cells at and after the deleted one take their neighbour's contents
  assign shift    = chain_in.hit_any | hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
      sel <= 1'b0;
    end else if (ctl.load) begin
      hit <= occupied && (value == ctl.value);
      sel <= occupied && (SEL_W'(idx) == SEL_W'(ctl.position));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.del && shift) begin
      value <= nbr_value;
      count <= nbr_count;
    end else if (ctl.inc && hit) begin
      count <= count + VAL_W'(1);
    end else if (ctl.dec && hit) begin
      count <= count - VAL_W'(1);
    end else if (ctl.app && (CNT_W'(idx) == ctl.used)) begin
      value <= ctl.value;
      count <= VAL_W'(1);
    end
  end

  always_comb begin
    chain_out.hit_any   = chain_in.hit_any | hit;
    chain_out.hit_count = chain_in.hit_count | (hit ? count : '0);
    chain_out.sel_any   = chain_in.sel_any | sel;
    chain_out.sel_count = chain_in.sel_count | (sel ? count : '0);
    chain_out.sel_value = chain_in.sel_value | (sel ? value : '0);
  end

endmodule

### rtl/counted_multiset_table.sv
// ----------------------------------------------------------------------------
// counted_multiset_table
// bag of 16-bit values with occurrence counts, kept in first-insertion order
// ----------------------------------------------------------------------------
// On the accepting edge every cell compares its value against the request
// and checks its own index against the position; in the execute cycle the
// matches are combined along the row of cells; once the request commits, the
// result is registered and the cells update (count up or down, append at the
// tail, or shift down by one to close the gap left by a deleted entry). The
// block holds one request at a time; req_stall is high during the execute
// cycle, and the execute cycle waits while an earlier response is still
// stalled in the output register. There is no clearing pass after reset:
// entries at or beyond the fill count are never looked at.
module counted_multiset_table import cmt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state;
  req_t               cmd;
  logic [CNT_W-1:0]   used;
  logic [TOTAL_W-1:0] running_total;

  logic               req_take;
  logic               commit;
  ctl_t               ctl;
  rsp_t               rsp_next;
  logic [CNT_W-1:0]   used_next;
  logic [TOTAL_W-1:0] total_next;

  link_t              chain [ENTRIES+1];
  logic [VAL_W-1:0]   cell_value [ENTRIES];
  logic [VAL_W-1:0]   cell_count [ENTRIES];
  logic [ENTRIES-1:0] cell_hit;

  // one request in flight at a time
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  // execute only once the output register is free or being drained
  assign commit    = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  // row of cells, each handing its reduction to the next
  assign chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [VAL_W-1:0] nbr_value;
    logic [VAL_W-1:0] nbr_count;

    if (i == ENTRIES - 1) begin : g_last
      // nothing beyond the last cell; what it takes lies past the fill count
      assign nbr_value = '0;
      assign nbr_count = '0;
    end else begin : g_mid
      assign nbr_value = cell_value[i+1];
      assign nbr_count = cell_count[i+1];
    end

    cmt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .nbr_value (nbr_value),
      .nbr_count (nbr_count),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .value     (cell_value[i]),
      .count     (cell_count[i]),
      .hit       (cell_hit[i])
    );
  end

  // decide the action from the combined match results
  always_comb begin
    ctl          = '0;
    ctl.load     = req_take;
    ctl.value    = (state == S_EXEC) ? cmd.value : req.value;
    ctl.position = req.position;
    ctl.used     = used;

    rsp_next     = '0;
    used_next    = used;
    total_next   = running_total;

    case (cmd.action)
      ACT_ADD: begin
        if (chain[ENTRIES].hit_any) begin
          if (chain[ENTRIES].hit_count == COUNT_MAX) begin
            // count saturated, refuse
            rsp_next.count = COUNT_MAX;
          end else begin
            ctl.inc        = commit;
            rsp_next.ok    = 1'b1;
            rsp_next.count = chain[ENTRIES].hit_count + VAL_W'(1);
            total_next     = running_total + TOTAL_W'(cmd.value);
          end
        end else if (used < CNT_W'(ENTRIES)) begin
          // new value goes to the tail
          ctl.app        = commit;
          rsp_next.ok    = 1'b1;
          rsp_next.count = VAL_W'(1);
          used_next      = used + CNT_W'(1);
          total_next     = running_total + TOTAL_W'(cmd.value);
        end
      end
      ACT_REMOVE: begin
        if (chain[ENTRIES].hit_any) begin
          rsp_next.ok = 1'b1;
          total_next  = running_total - TOTAL_W'(cmd.value);
          if (chain[ENTRIES].hit_count > VAL_W'(1)) begin
            ctl.dec        = commit;
            rsp_next.count = chain[ENTRIES].hit_count - VAL_W'(1);
          end else begin
            // last occurrence: delete and compact
            ctl.del   = commit;
            used_next = used - CNT_W'(1);
          end
        end
      end
      ACT_COUNT: begin
        rsp_next.ok    = chain[ENTRIES].hit_any;
        rsp_next.count = chain[ENTRIES].hit_count;
      end
      ACT_READ: begin
        rsp_next.ok          = chain[ENTRIES].sel_any;
        rsp_next.count       = chain[ENTRIES].sel_count;
        rsp_next.entry_value = chain[ENTRIES].sel_value;
      end
      default: begin
        rsp_next = '0;
      end
    endcase

    rsp_next.total    = total_next;
    rsp_next.distinct = DIST_W'(used_next);
  end

  // control and table summary
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used          <= '0;
      running_total <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (commit) begin
        used          <= used_next;
        running_total <= total_next;
        rsp_valid     <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid     <= 1'b0;
      end
    end
  end

  // request and response payload registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd <= req;
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // the fill count never passes the table size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(ENTRIES))
    else $error("fill count beyond table size");

  // stored values are unique, so at most one cell matches
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(cell_hit))
    else $error("more than one cell matched");

  // an accepted request always moves to the execute cycle
  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    req_take |=> (state == S_EXEC))
    else $error("accepted request not executed");

  // a completed request always presents a response
  a_commit_rsp: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp_valid)
    else $error("response lost after execute");
`endif

endmodule

### dv/counted_multiset_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counted_multiset_table_test
// self-checking bench for the counted multiset table: every accepted request
// is run through a local model of the bag and each reply is compared field by
// field with the oldest predicted reply, under random idling on both sides
// ----------------------------------------------------------------------------
module counted_multiset_table_test import cmt_pkg::*;;

  // --------------------------------------------------------------------------
  // scoreboard: keeps its own copy of the bag and the replies still awaited
  // --------------------------------------------------------------------------
  class multiset_ledger;
    logic [VAL_W-1:0]   held_value [ENTRIES];
    logic [VAL_W-1:0]   held_count [ENTRIES];
    int unsigned        fill;
    logic [TOTAL_W-1:0] weighted_sum;
    rsp_t               awaited_replies [$];
    int                 errors;
    int                 replies_seen;
    // coverage tallies for the closing summary
    int                 n_act [4];
    int                 n_refused;
    int                 n_missing;
    int                 peak_fill;
    bit                 hit_full;
    bit                 hit_saturation;

    function new();
      fill         = 0;
      weighted_sum = '0;
      errors       = 0;
      replies_seen = 0;
      n_refused    = 0;
      n_missing    = 0;
      peak_fill    = 0;
      hit_full     = 1'b0;
      hit_saturation = 1'b0;
      foreach (n_act[i]) n_act[i] = 0;
    endfunction

    // index of the entry holding v, or ENTRIES when v is not held
    function int unsigned locate(logic [VAL_W-1:0] v);
      for (int unsigned i = 0; i < fill; i++) begin
        if (held_value[i] == v) return i;
      end
      return ENTRIES;
    endfunction

    // apply one request to the local bag and work out its reply
    function rsp_t predict_reply(req_t item);
      rsp_t        r;
      int unsigned idx;
      r = '0;
      n_act[item.action]++;
      case (item.action)
        ACT_ADD: begin
          idx = locate(item.value);
          if (idx < ENTRIES) begin
            if (held_count[idx] == COUNT_MAX) begin
              r.count        = COUNT_MAX;
              hit_saturation = 1'b1;
              n_refused++;
            end else begin
              held_count[idx]++;
              weighted_sum += TOTAL_W'(item.value);
              r.count       = held_count[idx];
              r.ok          = 1'b1;
            end
          end else if (fill < ENTRIES) begin
            held_value[fill] = item.value;
            held_count[fill] = VAL_W'(1);
            fill++;
            weighted_sum += TOTAL_W'(item.value);
            r.count       = VAL_W'(1);
            r.ok          = 1'b1;
          end else begin
            hit_full = 1'b1;
            n_refused++;
          end
        end
        ACT_REMOVE: begin
          idx = locate(item.value);
          if (idx < ENTRIES) begin
            weighted_sum -= TOTAL_W'(item.value);
            if (held_count[idx] > 1) begin
              held_count[idx]--;
              r.count = held_count[idx];
            end else begin
              // last occurrence: close the gap
              for (int unsigned j = idx; j + 1 < fill; j++) begin
                held_value[j] = held_value[j+1];
                held_count[j] = held_count[j+1];
              end
              fill--;
            end
            r.ok = 1'b1;
          end else begin
            n_missing++;
          end
        end
        ACT_COUNT: begin
          idx = locate(item.value);
          if (idx < ENTRIES) begin
            r.count = held_count[idx];
            r.ok    = 1'b1;
          end
        end
        default: begin
          if (item.position < fill) begin
            r.entry_value = held_value[item.position];
            r.count       = held_count[item.position];
            r.ok          = 1'b1;
          end
        end
      endcase
      if (fill > peak_fill) peak_fill = fill;
      r.total    = weighted_sum;
      r.distinct = fill[DIST_W-1:0];
      return r;
    endfunction

    function void note_request(req_t item);
      rsp_t r;
      r = predict_reply(item);
      awaited_replies = {awaited_replies, r};
    endfunction

    function int awaited();
      return awaited_replies.size();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at reply %0d: %s got 0x%0h expected 0x%0h",
               replies_seen, what, got, want);
      errors++;
    endtask

    task check_reply(rsp_t got);
      rsp_t want;
      replies_seen++;
      if (awaited_replies.size() == 0) begin
        report("unexpected reply, total", 64'(got.total), 64'd0);
      end else begin
        want = awaited_replies.pop_front();
        if (got.ok !== want.ok)
          report("ok", 64'(got.ok), 64'(want.ok));
        if (got.count !== want.count)
          report("count", 64'(got.count), 64'(want.count));
        if (got.entry_value !== want.entry_value)
          report("entry_value", 64'(got.entry_value), 64'(want.entry_value));
        if (got.total !== want.total)
          report("total", 64'(got.total), 64'(want.total));
        if (got.distinct !== want.distinct)
          report("distinct", 64'(got.distinct), 64'(want.distinct));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  counted_multiset_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  multiset_ledger ledger = new();

  // shared controls between the sending and receiving processes
  bit no_idle       = 1'b0;  // idle-free stretch on both sides
  bit hold_off_ask  = 1'b0;  // asks the receiver for a long hold-off
  bit hold_started  = 1'b0;  // receiver has taken up the hold-off
  int hold_left     = 0;

  logic [VAL_W-1:0] value_pool [20];

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  function automatic req_t make_req(action_t a, logic [VAL_W-1:0] v,
                                    logic [POS_W-1:0] p);
    req_t r;
    r.action   = a;
    r.value    = v;
    r.position = p;
    return r;
  endfunction

  // offer one transfer and hold it until the block takes it, then maybe idle
  task automatic offer(input req_t item);
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    ledger.note_request(item);
    if (!no_idle && $urandom_range(99) < 8) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // sender pause: nothing offered until every awaited reply is back
  task automatic wait_for_replies();
    if (ledger.awaited() != 0) begin
      req_valid <= 1'b0;
      while (ledger.awaited() != 0) @(posedge clk);
    end
  endtask

  // random request: fill-heavy or drain-heavy mix, values mostly from a small
  // pool so that hits, refusals on a full table and deletions are common
  function automatic req_t random_req(bit filling);
    int unsigned roll;
    action_t     a;
    logic [VAL_W-1:0] v;
    roll = $urandom_range(99);
    if (filling)
      a = (roll < 45) ? ACT_ADD : (roll < 65) ? ACT_REMOVE :
          (roll < 80) ? ACT_COUNT : ACT_READ;
    else
      a = (roll < 20) ? ACT_ADD : (roll < 65) ? ACT_REMOVE :
          (roll < 80) ? ACT_COUNT : ACT_READ;
    if ($urandom_range(99) < 80)
      v = value_pool[$urandom_range(19)];
    else
      v = VAL_W'($urandom_range(16'hFFFF));
    return make_req(a, v, POS_W'($urandom_range(2**POS_W - 1)));
  endfunction

  // --------------------------------------------------------------------------
  // reply side: checks every transfer and stalls at random
  // --------------------------------------------------------------------------
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) ledger.check_reply(rsp);
      if (hold_off_ask && !hold_started) begin
        hold_left    = 300;
        hold_started = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= !no_idle && ($urandom_range(99) < 8);
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    value_pool[0]  = 16'h0000;
    value_pool[19] = 16'hFFFF;
    for (int i = 1; i < 19; i++) value_pool[i] = VAL_W'($urandom_range(16'hFFFF));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-table queries, extremes, duplicate, deletion with shift
    offer(make_req(ACT_COUNT,  16'h1234, 0));   // count of an absent value
    offer(make_req(ACT_READ,   16'h0000, 0));   // read on an empty table
    offer(make_req(ACT_REMOVE, 16'h0000, 0));   // remove of an absent value
    offer(make_req(ACT_ADD,    16'h0000, 0));
    offer(make_req(ACT_ADD,    16'hFFFF, 0));
    offer(make_req(ACT_ADD,    16'hFFFF, 0));   // duplicate raises the count
    offer(make_req(ACT_ADD,    16'h1234, 0));
    offer(make_req(ACT_READ,   16'h0000, 1));
    offer(make_req(ACT_COUNT,  16'hFFFF, 0));
    offer(make_req(ACT_REMOVE, 16'hFFFF, 0));   // count lowered
    offer(make_req(ACT_REMOVE, 16'h0000, 0));   // last occurrence, gap closed
    offer(make_req(ACT_READ,   16'h0000, 0));
    offer(make_req(ACT_READ,   16'h0000, 15));  // bad position
    // fill to the brim, then a new value is refused
    for (int i = 0; ledger.fill < ENTRIES; i++)
      offer(make_req(ACT_ADD, VAL_W'(16'hA5A0 + i), 0));
    offer(make_req(ACT_ADD,    16'h5A5A, 0));   // table full
    offer(make_req(ACT_READ,   16'h0000, 15));  // last slot, good position
    offer(make_req(ACT_REMOVE, 16'hA5A3, 0));   // deletion from the middle
    offer(make_req(ACT_REMOVE, 16'hFFFF, 0));   // deletion at the head
    wait_for_replies();

    // random traffic
    for (int n = 0; n < 1600; n++) begin
      if (n == 300) hold_off_ask = 1'b1;        // block fills and stalls input
      if (n == 800 || n == 1200) wait_for_replies();
      no_idle = (n >= 1000 && n < 1300);
      offer(random_req((n / 200) % 2 == 0));
    end
    no_idle = 1'b0;

    wait_for_replies();
    repeat (20) @(posedge clk);

    $display("covered %0d replies: %0d adds (%0d refused), %0d removes (%0d absent),",
             ledger.replies_seen, ledger.n_act[ACT_ADD], ledger.n_refused,
             ledger.n_act[ACT_REMOVE], ledger.n_missing);
    $display("%0d counts, %0d reads; peak fill %0d, full table %0b, saturated count %0b",
             ledger.n_act[ACT_COUNT], ledger.n_act[ACT_READ], ledger.peak_fill,
             ledger.hit_full, ledger.hit_saturation);
    if (ledger.errors == 0 && ledger.awaited() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/cmt_pkg.sv
rtl/cmt_cell.sv
rtl/counted_multiset_table.sv
dv/counted_multiset_table_test.sv
